// ===== rtl/ip_address_text_validator_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the address text validator
// Shared assertion forms, clocked on clk and held off during reset.
// ----------------------------------------------------------------------------
`ifndef IP_ADDRESS_TEXT_VALIDATOR_MACROS_SVH
`define IP_ADDRESS_TEXT_VALIDATOR_MACROS_SVH

// same-cycle implication
`define IPV_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define IPV_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/ipv_pkg.sv =====
// ----------------------------------------------------------------------------
// ipv_pkg
// Types and constants shared by the address text validator modules.
// ----------------------------------------------------------------------------
package ipv_pkg;

  // character classes seen by the checkers
  typedef enum logic [2:0] {
    CLS_DEC,
    CLS_HEX_ALPHA,
    CLS_DOT,
    CLS_COLON,
    CLS_OTHER
  } char_cls_t;

  typedef enum logic [1:0] {
    VERDICT_V4      = 2'd0,
    VERDICT_V6      = 2'd1,
    VERDICT_NEITHER = 2'd2
  } verdict_t;

  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_COLON = 8'h3A;

  localparam logic [2:0] V4_MAX_DIGITS = 3'd3;
  localparam logic [9:0] V4_MAX_VALUE  = 10'd255;
  localparam logic [2:0] V4_DOTS       = 3'd3;
  localparam logic [2:0] V4_DOT_SAT    = 3'd7;
  localparam logic [2:0] V6_MAX_DIGITS = 3'd4;
  localparam logic [3:0] V6_COLONS     = 4'd7;
  localparam logic [3:0] V6_COLON_SAT  = 4'd15;

  // one classified character travelling from front to back
  typedef struct packed {
    char_cls_t  cls;
    logic [3:0] digit;
    logic       last;
  } q_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  function automatic char_cls_t classify(input logic [7:0] ch);
    char_cls_t c;
    c = CLS_OTHER;
    if (ch >= 8'h30 && ch <= 8'h39) begin
      c = CLS_DEC;
    end else if ((ch >= 8'h41 && ch <= 8'h46) || (ch >= 8'h61 && ch <= 8'h66)) begin
      c = CLS_HEX_ALPHA;
    end else if (ch == CH_DOT) begin
      c = CLS_DOT;
    end else if (ch == CH_COLON) begin
      c = CLS_COLON;
    end
    return c;
  endfunction

endpackage

// ===== rtl/ipv_front.sv =====
// ----------------------------------------------------------------------------
// ipv_front
// Accepts characters, classifies them and holds one request for the queue.
// ----------------------------------------------------------------------------
module ipv_front
  import ipv_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] ch
  input  logic       in_tlast,   // last
  output logic       fe_valid,
  input  logic       fe_ready,
  output q_entry_t   fe_entry
);

  logic     fv_r;
  q_entry_t entry_r;

  assign in_tready = !fv_r || fe_ready;
  assign fe_valid  = fv_r;
  assign fe_entry  = entry_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      fv_r <= 1'b1;
    end else if (fe_ready) begin
      fv_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      entry_r.cls   <= classify(in_tdata);
      entry_r.digit <= in_tdata[3:0];
      entry_r.last  <= in_tlast;
    end
  end

endmodule

// ===== rtl/ipv_queue.sv =====
// ----------------------------------------------------------------------------
// ipv_queue
// Short queue of classified characters between front and back.
// ----------------------------------------------------------------------------
module ipv_queue
  import ipv_pkg::*;
#(
  parameter int QDEPTH = 4
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  q_entry_t  push_entry,
  input  logic      pop,
  output q_entry_t  head,
  output q_status_t status,
  output logic [$clog2(QDEPTH+1)-1:0] count
);

  localparam int PW = $clog2(QDEPTH);
  localparam int CW = $clog2(QDEPTH + 1);

  q_entry_t        mem [QDEPTH];
  logic [PW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]   count_r;
  logic            do_push, do_pop;

  assign status.full  = (count_r == CW'(QDEPTH));
  assign status.empty = (count_r == '0);
  assign count        = count_r;
  assign head         = mem[rd_ptr_r];
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/ipv_back.sv =====
// ----------------------------------------------------------------------------
// ipv_back
// Runs the IPv4 and IPv6 field checkers and registers the verdict.
// ----------------------------------------------------------------------------
module ipv_back
  import ipv_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_valid,
  input  q_entry_t   q_head,
  output logic       q_pop,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata   // [1:0] verdict, [7:2] zero
);

  logic [2:0] v4_len_r, v4_len_nxt;
  logic [9:0] v4_val_r, v4_val_nxt;
  logic       v4_fz_r, v4_fz_nxt;
  logic [2:0] v4_dots_r, v4_dots_nxt;
  logic       v4_inv_r, v4_inv_nxt;
  logic [2:0] v6_len_r, v6_len_nxt;
  logic [3:0] v6_colons_r, v6_colons_nxt;
  logic       v6_inv_r, v6_inv_nxt;
  logic       ov_r;
  verdict_t   verdict_r, verdict_nxt;
  logic [13:0] val_x10;

  // a last character needs the output slot, others pass straight through
  assign q_pop      = q_valid && (!q_head.last || !ov_r || out_tready);
  assign out_tvalid = ov_r;
  assign out_tdata  = {6'd0, verdict_r};
  assign val_x10    = {1'b0, v4_val_r, 3'b000} + {3'b000, v4_val_r, 1'b0}
                    + {10'd0, q_head.digit};

  function automatic logic v4_bad(input logic [2:0] len, input logic [9:0] val,
                                  input logic fz);
    return (len == 3'd0) || (len > V4_MAX_DIGITS) || (val > V4_MAX_VALUE) ||
           (fz && len > 3'd1);
  endfunction

  always_comb begin
    v4_len_nxt    = v4_len_r;
    v4_val_nxt    = v4_val_r;
    v4_fz_nxt     = v4_fz_r;
    v4_dots_nxt   = v4_dots_r;
    v4_inv_nxt    = v4_inv_r;
    v6_len_nxt    = v6_len_r;
    v6_colons_nxt = v6_colons_r;
    v6_inv_nxt    = v6_inv_r;
    verdict_nxt   = VERDICT_NEITHER;

    // IPv4 side
    case (q_head.cls)
      CLS_DOT: begin
        if (v4_bad(v4_len_r, v4_val_r, v4_fz_r)) v4_inv_nxt = 1'b1;
        v4_len_nxt = '0;
        v4_val_nxt = '0;
        v4_fz_nxt  = 1'b0;
        if (v4_dots_r < V4_DOT_SAT) v4_dots_nxt = v4_dots_r + 1'b1;
      end
      CLS_DEC: begin
        if (v4_len_r == 3'd0) v4_fz_nxt = (q_head.digit == 4'd0);
        if (v4_len_r < V4_MAX_DIGITS) v4_val_nxt = val_x10[9:0];
        if (v4_len_r <= V4_MAX_DIGITS) v4_len_nxt = v4_len_r + 1'b1;
      end
      default: v4_inv_nxt = 1'b1;
    endcase

    // IPv6 side
    case (q_head.cls) inside
      CLS_COLON: begin
        if (v6_len_r == 3'd0 || v6_len_r > V6_MAX_DIGITS) v6_inv_nxt = 1'b1;
        v6_len_nxt = '0;
        if (v6_colons_r < V6_COLON_SAT) v6_colons_nxt = v6_colons_r + 1'b1;
      end
      CLS_DEC, CLS_HEX_ALPHA: begin
        if (v6_len_r <= V6_MAX_DIGITS) v6_len_nxt = v6_len_r + 1'b1;
      end
      default: v6_inv_nxt = 1'b1;
    endcase

    // close both open fields and judge
    if (q_head.last) begin
      if (v4_bad(v4_len_nxt, v4_val_nxt, v4_fz_nxt)) v4_inv_nxt = 1'b1;
      if (v6_len_nxt == 3'd0 || v6_len_nxt > V6_MAX_DIGITS) v6_inv_nxt = 1'b1;
      if (!v4_inv_nxt && v4_dots_nxt == V4_DOTS) begin
        verdict_nxt = VERDICT_V4;
      end else if (!v6_inv_nxt && v6_colons_nxt == V6_COLONS) begin
        verdict_nxt = VERDICT_V6;
      end
      v4_len_nxt    = '0;
      v4_val_nxt    = '0;
      v4_fz_nxt     = 1'b0;
      v4_dots_nxt   = '0;
      v4_inv_nxt    = 1'b0;
      v6_len_nxt    = '0;
      v6_colons_nxt = '0;
      v6_inv_nxt    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_len_r    <= '0;
      v4_val_r    <= '0;
      v4_fz_r     <= 1'b0;
      v4_dots_r   <= '0;
      v4_inv_r    <= 1'b0;
      v6_len_r    <= '0;
      v6_colons_r <= '0;
      v6_inv_r    <= 1'b0;
      ov_r        <= 1'b0;
    end else begin
      if (q_pop) begin
        v4_len_r    <= v4_len_nxt;
        v4_val_r    <= v4_val_nxt;
        v4_fz_r     <= v4_fz_nxt;
        v4_dots_r   <= v4_dots_nxt;
        v4_inv_r    <= v4_inv_nxt;
        v6_len_r    <= v6_len_nxt;
        v6_colons_r <= v6_colons_nxt;
        v6_inv_r    <= v6_inv_nxt;
      end
      if (q_pop && q_head.last) begin
        ov_r <= 1'b1;
      end else if (out_tready) begin
        ov_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && q_head.last) begin
      verdict_r <= verdict_nxt;
    end
  end

endmodule

// ===== rtl/ip_address_text_validator.sv =====
// ----------------------------------------------------------------------------
// ip_address_text_validator
// Classifies a streamed address string as IPv4, IPv6 or neither.
// ----------------------------------------------------------------------------
// Send the address one ASCII character per request, tlast on the final one.
// One character is taken every cycle while the result side keeps up; the
// verdict (0 IPv4, 1 IPv6, 2 neither) leaves once the last character has
// passed the classifying input register, the character queue and the
// verdict output register. The queue of QDEPTH entries absorbs result-side
// stalls before the input side backs up.
// Checker state clears after every verdict.
module ip_address_text_validator
  import ipv_pkg::*;
#(
  parameter int QDEPTH = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] ch
  input  logic       in_tlast,   // last
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata   // [1:0] verdict, [7:2] zero
);

  `include "ip_address_text_validator_macros.svh"

  logic      fe_valid;
  q_entry_t  fe_entry;
  q_entry_t  q_head;
  q_status_t q_status;
  logic      q_pop;
  logic [$clog2(QDEPTH+1)-1:0] q_count;

  ipv_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .fe_valid  (fe_valid),
    .fe_ready  (!q_status.full),
    .fe_entry  (fe_entry)
  );

  ipv_queue #(.QDEPTH(QDEPTH)) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (fe_valid),
    .push_entry (fe_entry),
    .pop        (q_pop),
    .head       (q_head),
    .status     (q_status),
    .count      (q_count)
  );

  ipv_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (!q_status.empty),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  `IPV_ASSERT_NOW(a_verdict_code, out_tvalid, out_tdata[1:0] != 2'd3, "bad verdict code")
  `IPV_ASSERT_NOW(a_queue_bound, 1'b1, q_count <= QDEPTH, "queue count overflow")
  `IPV_ASSERT_NOW(a_stall_cause, !in_tready, fe_valid && q_status.full, "input stalled without cause")
  `IPV_ASSERT_NEXT(a_queue_fill, fe_valid && !q_status.full && !q_pop, !q_status.empty, "push lost")

endmodule

// ===== dv/ip_address_text_validator_test.sv =====
// ----------------------------------------------------------------------------
// ip_address_text_validator_test
// Streams address strings into the validator one character per request and
// checks each verdict against a predictor of the IPv4 and IPv6 checkers.
// A short table of strings comes first. Random strings follow: dotted
// decimal, colon hex, separator runs and raw bytes. These run under several
// idling patterns and include one long result-side hold-off.
// ----------------------------------------------------------------------------
module ip_address_text_validator_test
  import ipv_pkg::*;
();

  localparam int N_DIR        = 5;
  localparam int PHASE_CHARS  = 425;
  localparam int LONG_HOLD    = 300;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 12;

  typedef struct packed {
    logic [4:0]   len;
    logic [119:0] txt;      // characters right-justified, first one highest
    logic         typed;    // verdict below is taken as the expectation
    verdict_t     verdict;
  } dir_row_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata = 8'd0;    // [7:0] ch
  logic       in_tlast = 1'b0;    // last
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;          // [1:0] verdict, [7:2] zero

  // predictor state, decimal side
  logic [2:0] dec_len = 3'd0;
  logic [9:0] dec_value = 10'd0;
  logic       dec_lead_zero = 1'b0;
  logic [2:0] dot_cnt = 3'd0;
  logic       dec_bad = 1'b0;
  // predictor state, hex side
  logic [2:0] hex_len = 3'd0;
  logic [3:0] colon_cnt = 4'd0;
  logic       hex_bad = 1'b0;

  verdict_t   pending_verdicts[$];
  logic [7:0] text_q[$];
  verdict_t   want_verdict;

  int chars_sent   = 0;
  int tx_idle_pct  = 0;
  int rx_stall_pct = 0;
  int hold_reqs    = 0;
  int hold_seen    = 0;
  int mismatches   = 0;
  int idle_cycles  = 0;

  int tx_idle_by_phase  [4] = '{0, 79, 0, 33};
  int rx_stall_by_phase [4] = '{0, 0, 79, 33};

  string hex_digits = "0123456789abcdefABCDEF";
  string sep_mix    = ".:.:0019aF";

  dir_row_t dir_rows [N_DIR] = '{
    '{5'd1,  120'h00,            1'b1, VERDICT_NEITHER},  // lowest byte alone
    '{5'd1,  120'hFF,            1'b1, VERDICT_NEITHER},  // highest byte alone
    '{5'd7,  "1.2.3.4",          1'b0, VERDICT_NEITHER},
    '{5'd1,  ".",                1'b1, VERDICT_NEITHER},  // nothing but a separator
    '{5'd15, "0:0:0:0:0:0:0:0",  1'b0, VERDICT_NEITHER}
  };

  ip_address_text_validator u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic bit is_dec_char(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic bit is_hex_char(input logic [7:0] c);
    return is_dec_char(c) || (c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66);
  endfunction

  task automatic close_dec_field();
    if (dec_len == 3'd0 || dec_len > V4_MAX_DIGITS || dec_value > V4_MAX_VALUE ||
        (dec_lead_zero && dec_len > 3'd1)) begin
      dec_bad = 1'b1;
    end
    dec_len = 3'd0;
    dec_value = 10'd0;
    dec_lead_zero = 1'b0;
  endtask

  task automatic close_hex_field();
    if (hex_len == 3'd0 || hex_len > V6_MAX_DIGITS) begin
      hex_bad = 1'b1;
    end
    hex_len = 3'd0;
  endtask

  // Advance both checkers by one character; form the verdict on the last one.
  task automatic judge_char(input logic [7:0] c, input logic l, output bit has,
                            output verdict_t v);
    logic [3:0] d;
    has = 1'b0;
    v = VERDICT_NEITHER;
    d = c[3:0];
    if (c == CH_DOT) begin
      close_dec_field();
      if (dot_cnt < V4_DOT_SAT) dot_cnt = dot_cnt + 3'd1;
    end else if (is_dec_char(c)) begin
      if (dec_len == 3'd0) dec_lead_zero = (d == 4'd0);
      if (dec_len < V4_MAX_DIGITS) dec_value = dec_value * 10'd10 + {6'd0, d};
      if (dec_len <= V4_MAX_DIGITS) dec_len = dec_len + 3'd1;
    end else begin
      dec_bad = 1'b1;
    end
    if (c == CH_COLON) begin
      close_hex_field();
      if (colon_cnt < V6_COLON_SAT) colon_cnt = colon_cnt + 4'd1;
    end else if (is_hex_char(c)) begin
      if (hex_len <= V6_MAX_DIGITS) hex_len = hex_len + 3'd1;
    end else begin
      hex_bad = 1'b1;
    end
    if (l) begin
      close_dec_field();
      close_hex_field();
      has = 1'b1;
      if (!dec_bad && dot_cnt == V4_DOTS) begin
        v = VERDICT_V4;
      end else if (!hex_bad && colon_cnt == V6_COLONS) begin
        v = VERDICT_V6;
      end
      dot_cnt = 3'd0;
      dec_bad = 1'b0;
      colon_cnt = 4'd0;
      hex_bad = 1'b0;
    end
  endtask

  task automatic send_char(input logic [7:0] c, input logic l, input bit typed,
                           input verdict_t typed_v);
    bit has;
    verdict_t v;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= c;
    in_tlast <= l;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    judge_char(c, l, has, v);
    if (has) pending_verdicts = {pending_verdicts, (typed ? typed_v : v)};
    chars_sent++;
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_verdicts.size() != 0);
  endtask

  // add one character to the end of the text under construction
  task automatic append_char(input logic [7:0] c);
    text_q = {text_q, c};
  endtask

  // Fill text_q with one random address string, mostly near-valid.
  task automatic build_text();
    int kind, nf, r, n, k, j, raw;
    string s;
    text_q.delete();
    kind = $urandom_range(99);
    if (kind < 40) begin
      nf = ($urandom_range(9) == 0) ? $urandom_range(1, 9) : 4;
      for (k = 0; k < nf; k++) begin
        if (k != 0) append_char(CH_DOT);
        r = $urandom_range(99);
        if (r < 78) s = $sformatf("%0d", $urandom_range(255));
        else if (r < 85) s = $sformatf("0%0d", $urandom_range(99));
        else if (r < 92) s = $sformatf("%0d", $urandom_range(999, 256));
        else if (r < 96) s = "";
        else s = $sformatf("%0d", $urandom_range(999999, 1000));
        for (j = 0; j < s.len(); j++) append_char(s[j]);
      end
    end else if (kind < 80) begin
      nf = ($urandom_range(9) == 0) ? $urandom_range(1, 18) : 8;
      for (k = 0; k < nf; k++) begin
        if (k != 0) append_char(CH_COLON);
        r = $urandom_range(99);
        if (r < 85) n = $urandom_range(4, 1);
        else if (r < 93) n = 0;
        else n = $urandom_range(7, 5);
        for (j = 0; j < n; j++) append_char(hex_digits[$urandom_range(21)]);
      end
    end else if (kind < 90) begin
      n = $urandom_range(24, 1);
      for (j = 0; j < n; j++) append_char(sep_mix[$urandom_range(sep_mix.len() - 1)]);
    end else begin
      n = $urandom_range(16, 1);
      for (j = 0; j < n; j++) begin
        raw = $urandom_range(255);
        append_char(raw[7:0]);
      end
    end
    if (text_q.size() == 0) append_char(CH_DOT);
    // corrupt one character now and then
    if ($urandom_range(19) == 0) begin
      raw = $urandom_range(255);
      text_q[$urandom_range(text_q.size() - 1)] = raw[7:0];
    end
  endtask

  // result side: random stalls, or one long hold-off when requested
  initial begin
    forever begin
      @(posedge clk);
      if (hold_seen != hold_reqs) begin
        hold_seen = hold_reqs;
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        out_tready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  task automatic note_mismatch(input string what, input logic [7:0] want,
                               input logic [7:0] got);
    if (mismatches < 10) $display("mismatch (%s): expected %02h, got %02h", what, want, got);
    mismatches++;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_verdicts.size() == 0) begin
        note_mismatch("unexpected verdict", 8'hxx, out_tdata);
      end else begin
        want_verdict = pending_verdicts.pop_front();
        if (out_tdata !== {6'd0, want_verdict}) begin
          note_mismatch("verdict", {6'd0, want_verdict}, out_tdata);
        end
      end
    end
  end

  // drop the run if nothing moves on either side for too long
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    dir_row_t row;
    logic [119:0] txt;
    int i, k, ph, target;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    for (i = 0; i < N_DIR; i++) begin
      row = dir_rows[i];
      txt = row.txt;
      for (k = 0; k < int'(row.len); k++) begin
        send_char(txt[8 * (int'(row.len) - 1 - k) +: 8], k == int'(row.len) - 1,
                  row.typed, row.verdict);
      end
    end
    wait_drained();

    for (ph = 0; ph < 4; ph++) begin
      tx_idle_pct = tx_idle_by_phase[ph];
      rx_stall_pct = rx_stall_by_phase[ph];
      target = chars_sent + PHASE_CHARS;
      // hold the result side while the sender keeps offering characters
      if (ph == 0) hold_reqs++;
      while (chars_sent < target) begin
        build_text();
        for (k = 0; k < text_q.size(); k++) begin
          send_char(text_q[k], k == text_q.size() - 1, 1'b0, VERDICT_NEITHER);
        end
      end
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_verdicts.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
